FILE: src/nar_pkg.sv
`timescale 1ns / 1ps

package nar_pkg;

  localparam int SYMBOLS    = 256;
  localparam int COUNT_BITS = 16;
  localparam int SYM_BITS   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int TOTAL_BITS = COUNT_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_EMIT  = 2'd2;

  localparam logic [2:0] ST_ACK        = 3'd0;
  localparam logic [2:0] ST_EMITTED    = 3'd1;
  localparam logic [2:0] ST_IMPOSSIBLE = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_WR,
    S_EMIT_CHECK,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic res_ack;
    logic load_read;
    logic load_update;
    logic emit_check;
    logic scan_start;
    logic scan_issue;
    logic emit_finish;
    logic push_out;
  } cmd_t;

  typedef struct packed {
    logic sym_ok;
    logic need_scan;
    logic scan_end;
    logic out_free;
  } stat_t;

endpackage

FILE: src/nar_ctrl.sv
`timescale 1ns / 1ps

module nar_ctrl
  import nar_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_mode,
  output logic       in_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            MODE_LOAD: state_next = stat.sym_ok ? S_LOAD_WR : S_FIN;
            MODE_EMIT: state_next = S_EMIT_CHECK;
            default:   state_next = S_FIN;
          endcase
        end
      end
      S_LOAD_WR:    state_next = S_FIN;
      S_EMIT_CHECK: state_next = stat.need_scan ? S_SCAN : S_FIN;
      S_SCAN: begin
        if (stat.scan_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_DECIDE;
      S_DECIDE: state_next = S_FIN;
      S_FIN: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (in_mode)
            MODE_CLEAR: cmd.clear = 1'b1;
            MODE_LOAD: begin
              cmd.load_read = stat.sym_ok;
              cmd.res_ack   = !stat.sym_ok;
            end
            MODE_EMIT: cmd.capture = 1'b1;
            default:   cmd.res_ack = 1'b1;
          endcase
        end
      end
      S_LOAD_WR: cmd.load_update = 1'b1;
      S_EMIT_CHECK: begin
        cmd.emit_check = 1'b1;
        cmd.scan_start = stat.need_scan;
      end
      S_SCAN:   cmd.scan_issue = 1'b1;
      S_DRAIN:  cmd.capture = 1'b0;
      S_DECIDE: cmd.emit_finish = 1'b1;
      S_FIN:    cmd.push_out = stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

FILE: src/nar_datapath.sv
`timescale 1ns / 1ps

module nar_datapath
  import nar_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_symbol,
  input  cmd_t       cmd,
  output stat_t      stat,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic [2:0] out_status,
  output logic       out_last
);

  logic [COUNT_BITS-1:0] mem [SYMBOLS];
  logic [SYMBOLS-1:0]    valid;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  rd_valid;
  logic [SYM_BITS-1:0]   rd_addr;
  logic                  rd_scan;

  logic [SYM_BITS-1:0]   sym_r;
  logic [TOTAL_BITS-1:0] total;
  logic [COUNT_BITS-1:0] largest;
  logic [SYM_BITS-1:0]   prev_sym;
  logic                  prev_valid;
  logic                  checked;
  logic                  impossible;

  logic [SYM_BITS-1:0]   scan_idx;
  logic [COUNT_BITS-1:0] best;
  logic [SYM_BITS-1:0]   pick;

  logic [7:0]            res_sym;
  logic [2:0]            res_status;
  logic                  res_last;

  logic [SYM_BITS-1:0]   mem_raddr;
  logic [SYM_BITS-1:0]   mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  mem_we;
  logic [COUNT_BITS-1:0] load_cnt;
  logic [COUNT_BITS-1:0] load_cnt_inc;
  logic                  load_ovf;
  logic [COUNT_BITS-1:0] cand;
  logic                  cand_skip;
  logic [TOTAL_BITS:0]   total_inc;
  logic [TOTAL_BITS-1:0] half_total;
  logic                  too_big;

  assign load_cnt     = rd_valid ? rd_data : '0;
  assign load_cnt_inc = load_cnt + COUNT_BITS'(1);
  assign load_ovf     = (load_cnt == COUNT_MAX) || (total == TOTAL_MAX);
  assign cand         = rd_valid ? rd_data : '0;
  assign cand_skip    = prev_valid && (rd_addr == prev_sym);
  assign total_inc    = {1'b0, total} + (TOTAL_BITS + 1)'(1);
  assign half_total   = total_inc[TOTAL_BITS:1];
  assign too_big      = {1'b0, largest} > half_total;

  assign mem_raddr = cmd.load_read ? in_symbol[SYM_BITS-1:0] : scan_idx;
  assign mem_waddr = cmd.load_update ? sym_r : pick;
  assign mem_wdata = cmd.load_update ? load_cnt_inc : best - COUNT_BITS'(1);
  assign mem_we    = (cmd.load_update && !load_ovf) || (cmd.emit_finish && best != '0);

  assign stat.sym_ok    = {1'b0, in_symbol} < 9'(SYMBOLS);
  assign stat.need_scan = !impossible && !(!checked && too_big) && (total != '0);
  assign stat.scan_end  = scan_idx == SYM_BITS'(SYMBOLS - 1);
  assign stat.out_free  = !out_valid || out_ready;

  // count store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data  <= mem[mem_raddr];
    rd_valid <= valid[mem_raddr];
    rd_addr  <= mem_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= '0;
    end else if (mem_we) begin
      valid[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_scan <= 1'b0;
    end else begin
      rd_scan <= cmd.scan_issue;
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      total      <= '0;
      largest    <= '0;
      prev_sym   <= '0;
      prev_valid <= 1'b0;
      checked    <= 1'b0;
      impossible <= 1'b0;
    end else begin
      if (cmd.load_update && !load_ovf) begin
        total <= total + TOTAL_BITS'(1);
        if (load_cnt_inc > largest) begin
          largest <= load_cnt_inc;
        end
      end
      if (cmd.emit_check && !impossible) begin
        checked <= 1'b1;
        if (!checked && too_big) begin
          impossible <= 1'b1;
        end
      end
      if (cmd.emit_finish) begin
        if (best == '0) begin
          impossible <= 1'b1;
        end else begin
          total      <= total - TOTAL_BITS'(1);
          prev_sym   <= pick;
          prev_valid <= 1'b1;
        end
      end
    end
  end

  // argmax scan, one entry per cycle, ties to the later code
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sym_r <= in_symbol[SYM_BITS-1:0];
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
      best     <= '0;
      pick     <= '0;
    end else begin
      if (cmd.scan_issue) begin
        scan_idx <= scan_idx + SYM_BITS'(1);
      end
      if (rd_scan && !cand_skip && cand != '0 && cand >= best) begin
        best <= cand;
        pick <= rd_addr;
      end
    end
  end

  // result of the current item
  always_ff @(posedge clk) begin
    if (cmd.clear || cmd.res_ack) begin
      res_sym    <= '0;
      res_status <= ST_ACK;
      res_last   <= 1'b0;
    end
    if (cmd.load_update) begin
      res_sym    <= '0;
      res_status <= load_ovf ? ST_OVERFLOW : ST_ACK;
      res_last   <= 1'b0;
    end
    if (cmd.emit_check && !stat.need_scan) begin
      res_sym    <= '0;
      res_status <= (impossible || (!checked && too_big)) ? ST_IMPOSSIBLE : ST_EMPTY;
      res_last   <= 1'b0;
    end
    if (cmd.emit_finish) begin
      if (best == '0) begin
        res_sym    <= '0;
        res_status <= ST_IMPOSSIBLE;
        res_last   <= 1'b0;
      end else begin
        res_sym    <= 8'(pick);
        res_status <= ST_EMITTED;
        res_last   <= total == TOTAL_BITS'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_out) begin
      out_symbol <= res_sym;
      out_status <= res_status;
      out_last   <= res_last;
    end
  end

endmodule

FILE: src/no_adjacent_repeat_rearranger_top.sv
// path from accept to result on the output register: clear and unused mode go to S_FIN,
// load via S_LOAD_WR, emit via S_EMIT_CHECK, then S_SCAN, S_DRAIN, S_DECIDE if it scans
// throughput: one item at a time, the next is taken the cycle after the result is
// registered; an emit scans the count memory one entry per cycle through its single
// read port, and a result still waiting on the output register holds back the next one
// rst is synchronous active high and empties all counts, flags and the output
`timescale 1ns / 1ps

module no_adjacent_repeat_rearranger_top
  import nar_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // symbol
  input  logic [1:0] s_axis_tuser,   // mode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_symbol
  output logic [2:0] m_axis_tuser,   // status
  output logic       m_axis_tlast
);

  cmd_t  cmd;
  stat_t stat;

  nar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nar_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_symbol  (s_axis_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_symbol (m_axis_tdata),
    .out_status (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

endmodule

FILE: src/nar_checker.sv
`timescale 1ns / 1ps

module nar_checker
  import nar_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output item present after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled output item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  a_non_emit_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_EMITTED |-> m_axis_tdata == 8'd0 && !m_axis_tlast)
    else $error("non emit result carries a symbol or last flag");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser == ST_ACK || m_axis_tuser == ST_EMITTED
      || m_axis_tuser == ST_IMPOSSIBLE || m_axis_tuser == ST_EMPTY
      || m_axis_tuser == ST_OVERFLOW)
    else $error("unknown status code");

endmodule

bind no_adjacent_repeat_rearranger_top nar_checker u_nar_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import nar_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1350;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [7:0] sym;
    logic [2:0] status;
    logic       last;
  } arranged_t;

  class rearrange_scoreboard;
    logic [COUNT_BITS-1:0] tally [SYMBOLS];
    logic [TOTAL_BITS-1:0] remaining;
    logic [COUNT_BITS-1:0] peak;
    logic [7:0]            prev_sym;
    bit                    prev_ok;
    bit                    verified;
    bit                    blocked;
    arranged_t             want_q [$];
    int                    errors;

    function new();
      wipe();
      errors = 0;
    endfunction

    function void wipe();
      foreach (tally[i]) tally[i] = '0;
      remaining = '0;
      peak      = '0;
      prev_sym  = '0;
      prev_ok   = 0;
      verified  = 0;
      blocked   = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function void note_item(logic [1:0] mode, logic [7:0] sym);
      arranged_t             r;
      logic [COUNT_BITS-1:0] best;
      int                    pick;
      r = '0;
      case (mode)
        MODE_CLEAR: begin
          wipe();
        end
        MODE_LOAD: begin
          if (int'(sym) < SYMBOLS) begin
            if (tally[sym] == COUNT_MAX || remaining == TOTAL_MAX) begin
              r.status = ST_OVERFLOW;
            end else begin
              tally[sym] = tally[sym] + 1'b1;
              remaining  = remaining + 1'b1;
              if (tally[sym] > peak) peak = tally[sym];
            end
          end
        end
        MODE_EMIT: begin
          if (blocked) begin
            r.status = ST_IMPOSSIBLE;
          end else if (!verified && int'(peak) > (int'(remaining) + 1) / 2) begin
            verified = 1;
            blocked  = 1;
            r.status = ST_IMPOSSIBLE;
          end else begin
            verified = 1;
            if (remaining == '0) begin
              r.status = ST_EMPTY;
            end else begin
              best = '0;
              pick = 0;
              for (int s = 0; s < SYMBOLS; s++) begin
                if (!(prev_ok && s == int'(prev_sym)) && tally[s] != '0 && tally[s] >= best) begin
                  best = tally[s];
                  pick = s;
                end
              end
              // only the previous symbol is left
              if (best == '0) begin
                blocked  = 1;
                r.status = ST_IMPOSSIBLE;
              end else begin
                tally[pick] = tally[pick] - 1'b1;
                remaining   = remaining - 1'b1;
                prev_sym    = pick[7:0];
                prev_ok     = 1;
                r.sym       = pick[7:0];
                r.status    = ST_EMITTED;
                r.last      = (remaining == '0);
              end
            end
          end
        end
        default: begin
        end
      endcase
      want_q.insert(want_q.size(), r);
    endfunction

    function void check_item(logic [7:0] sym, logic [2:0] status, logic last);
      arranged_t w;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t unexpected item: sym %02h status %0d last %0d", $time, sym, status, last);
      end else begin
        w = want_q.pop_front();
        if (w.sym !== sym || w.status !== status || w.last !== last) begin
          errors++;
          $display("%0t mismatch: expected sym %02h status %0d last %0d, got sym %02h status %0d last %0d",
                   $time, w.sym, w.status, w.last, sym, status, last);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  rearrange_scoreboard sb;
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold;
  int items_sent;
  int cycle_count;

  no_adjacent_repeat_rearranger_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts plus a long hold requested by the stimulus
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_item(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  task automatic send_item(logic [1:0] mode, logic [7:0] sym);
    int gap;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= sym;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(mode, sym);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // clear, load a small multiset, then emit it back, with optional extra loads and a reload
  task automatic run_arrangement();
    logic [7:0] alpha [6];
    logic [7:0] base;
    int k;
    int n;
    int extra;
    base = 8'($urandom_range(0, 255));
    k = $urandom_range(1, 6);
    for (int i = 0; i < 6; i++) begin
      alpha[i] = ($urandom_range(0, 1) == 0) ? base + i[7:0] : 8'($urandom_range(0, 255));
    end
    n = $urandom_range(1, 12);
    send_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) send_item(MODE_LOAD, alpha[0]);
      else send_item(MODE_LOAD, alpha[$urandom_range(0, k - 1)]);
    end
    for (int i = 0; i < n / 2; i++) send_item(MODE_EMIT, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      extra = $urandom_range(1, 3);
      for (int i = 0; i < extra; i++) send_item(MODE_LOAD, alpha[$urandom_range(0, k - 1)]);
      n += extra;
    end
    for (int i = n / 2; i < n + $urandom_range(0, 1); i++) begin
      send_item(MODE_EMIT, 8'($urandom_range(0, 255)));
    end
    // reload the symbol just emitted so that it is the only one left
    if ($urandom_range(0, 3) == 0 && sb.prev_ok) begin
      send_item(MODE_LOAD, sb.prev_sym);
      send_item(MODE_EMIT, 8'($urandom_range(0, 255)));
      send_item(MODE_LOAD, 8'($urandom_range(0, 255)));
      send_item(MODE_EMIT, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_infeasible();
    logic [7:0] major;
    int m;
    int others;
    major = 8'($urandom_range(0, 255));
    m = $urandom_range(2, 6);
    others = $urandom_range(0, m - 2);
    send_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
    for (int i = 0; i < m; i++) send_item(MODE_LOAD, major);
    for (int i = 0; i < others; i++) send_item(MODE_LOAD, major ^ 8'h01);
    send_item(MODE_EMIT, 8'($urandom_range(0, 255)));
    send_item(MODE_EMIT, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_noise();
    int len;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_backpressure();
    rx_hold = $urandom_range(300, 600);
    for (int i = 0; i < 10; i++) begin
      send_item(($urandom_range(0, 2) == 0) ? MODE_EMIT : MODE_LOAD,
                8'($urandom_range(0, 255)));
    end
    wait_drained();
  endtask

  initial begin
    int kind;
    int iter;
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tuser = MODE_CLEAR;
    tx_idle_on = 1;
    rx_idle_on = 1;
    rx_hold = 0;
    items_sent = 0;
    cycle_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty emit, unused mode, tie order, last flag
    send_item(MODE_EMIT, 8'h00);
    send_item(MODE_UNUSED, 8'hff);
    send_item(MODE_LOAD, 8'h00);
    send_item(MODE_LOAD, 8'hff);
    send_item(MODE_LOAD, 8'hff);
    send_item(MODE_LOAD, 8'h00);
    repeat (5) send_item(MODE_EMIT, 8'hff);
    // previous symbol only, then load while impossible
    send_item(MODE_LOAD, 8'h00);
    send_item(MODE_EMIT, 8'h00);
    send_item(MODE_LOAD, 8'h55);
    send_item(MODE_EMIT, 8'haa);
    // largest count too big
    send_item(MODE_CLEAR, 8'hff);
    repeat (3) send_item(MODE_LOAD, 8'h07);
    send_item(MODE_LOAD, 8'h09);
    send_item(MODE_EMIT, 8'h00);
    send_item(MODE_CLEAR, 8'h00);
    wait_drained();

    items_sent = 0;
    iter = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET - 150) begin
        tx_idle_on = 0;
        rx_idle_on = 0;
      end else begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      kind = (iter == 0) ? 9 : $urandom_range(0, (items_sent > ITEM_TARGET - 150) ? 8 : 9);
      if (kind <= 5) run_arrangement();
      else if (kind <= 6) run_noise();
      else if (kind <= 8) run_infeasible();
      else run_backpressure();
      iter++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
